// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the parser RTL.
// Needs a clock and an active-low synchronous reset at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/txp_pkg.sv -----
// Shared types and codes for the transaction / block stream parser.
// No dependencies.
`default_nettype none
package txp_pkg;

    localparam logic [4:0] FC_LOCK = 5'd15;
    localparam logic [4:0] FC_IDLE = 5'd18;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TRUNC     = 3'd1;
    localparam logic [2:0] ERR_NONCANON  = 3'd2;
    localparam logic [2:0] ERR_OVERSIZE  = 3'd3;
    localparam logic [2:0] ERR_MARKER    = 3'd4;
    localparam logic [2:0] ERR_EMPTY_WIT = 3'd5;

    localparam logic [1:0] CFG_PARSE_MODE = 2'd0;
    localparam logic [1:0] CFG_WITNESS    = 2'd1;
    localparam logic [1:0] CFG_SIZE_LIMIT = 2'd2;

    localparam logic [1:0] MODE_TX = 2'd0;

    typedef struct packed {
        logic [4:0]  field_code;
        logic [7:0]  byte_echo;
        logic [24:0] item_index;
        logic        tx_done;
        logic        message_done;
        logic        error_flag;
        logic [2:0]  error_code;
    } t_result;

    typedef struct packed {
        logic [1:0]  parse_mode;
        logic        witness_allowed;
        logic [25:0] size_limit;
    } t_cfg;

endpackage
`default_nettype wire

// ----- rtl/core/tx_block_stream_parser.sv -----
// Results are registered: each appears the cycle after its byte is accepted.
// Throughput: one byte per cycle; the single next-state pass in txp_core
// plus one output register sets this, and input stalls only while a
// finished result waits downstream. Synchronous active-low reset clears
// parser state and loads register defaults (mode 0, witness on, max 2^25).
`default_nettype none
`include "assert_macros.svh"
module tx_block_stream_parser #(
    parameter int COUNT_WIDTH = 26
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic        i_s_axis_tuser,   // [0] kind
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [4:0] field_code, [12:5] byte_echo, [37:13] item_index, [38] tx_done,
    // [39] message_done, [40] error_flag, [43:41] error_code, [47:44] zero
    output logic [47:0]      o_m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [25:0] i_cfg_wdata
);
    txp_pkg::t_cfg    r_cfg;
    txp_pkg::t_result w_res;
    txp_pkg::t_result r_res;
    logic             r_valid;
    logic             w_acc;

    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign w_acc = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.parse_mode      <= txp_pkg::MODE_TX;
            r_cfg.witness_allowed <= 1'b1;
            r_cfg.size_limit      <= 26'd33554432;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                txp_pkg::CFG_PARSE_MODE: r_cfg.parse_mode      <= i_cfg_wdata[1:0];
                txp_pkg::CFG_WITNESS:    r_cfg.witness_allowed <= i_cfg_wdata[0];
                txp_pkg::CFG_SIZE_LIMIT: r_cfg.size_limit      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    txp_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_acc),
        .i_kind  (i_s_axis_tuser),
        .i_byte  (i_s_axis_tdata),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_acc) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
        if (w_acc) begin
            r_res <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {4'd0, r_res.error_code, r_res.error_flag, r_res.message_done,
                              r_res.tx_done, r_res.item_index, r_res.byte_echo,
                              r_res.field_code};

    `ASSERT_CLK(a_flag_has_code, i_clk, i_rst_n,
        !r_valid || (r_res.error_flag == (r_res.error_code != txp_pkg::ERR_NONE)) ||
        (r_res.field_code == txp_pkg::FC_IDLE), "error flag and code disagree")
    `ASSERT_CLK(a_txdone_on_lock, i_clk, i_rst_n,
        !r_valid || !r_res.tx_done || (r_res.field_code == txp_pkg::FC_LOCK),
        "tx_done outside locktime")
    `ASSERT_CLK(a_eos_result, i_clk, i_rst_n,
        (w_acc && i_s_axis_tuser) |=> (r_valid && r_res.field_code == txp_pkg::FC_IDLE
        && r_res.byte_echo == 8'd0), "end of stream result missing")
    `ASSERT_ALWAYS(a_reset_clears, i_clk,
        !i_rst_n |=> !r_valid, "output valid after reset")

endmodule
`default_nettype wire

// ----- rtl/core/txp_core.sv -----
// Parser state and per-byte next-state logic; produces one result per request.
// Depends on txp_pkg.
`default_nettype none
module txp_core #(
    parameter int COUNT_WIDTH = 26
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_kind,
    input  wire logic [7:0]       i_byte,
    input  wire txp_pkg::t_cfg    i_cfg,
    output txp_pkg::t_result      o_res
);
    localparam int CW = COUNT_WIDTH;

    typedef enum logic [4:0] {
        PH_VERSION = 5'd0, PH_INCOUNT = 5'd1, PH_MARKER = 5'd2, PH_HASH = 5'd3,
        PH_INDEX = 5'd4, PH_SSLEN = 5'd5, PH_SSBYTE = 5'd6, PH_SEQ = 5'd7,
        PH_OUTCOUNT = 5'd8, PH_VALUE = 5'd9, PH_SPKLEN = 5'd10, PH_SPKBYTE = 5'd11,
        PH_WSTACK = 5'd12, PH_WLEN = 5'd13, PH_WBYTE = 5'd14, PH_LOCK = 5'd15,
        PH_HEADER = 5'd16, PH_TXCOUNT = 5'd17, PH_IDLE = 5'd18, PH_START = 5'd19
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [6:0]      r_fbc, n_fbc;
    logic [63:0]     r_acc, n_acc;
    logic [3:0]      r_pbl, n_pbl;
    logic [CW-1:0]   r_total, n_total;
    logic [CW-1:0]   r_list, n_list;
    logic [CW-1:0]   r_bytes, n_bytes;
    logic [CW-1:0]   r_stack, n_stack;
    logic [CW-1:0]   r_txrem, n_txrem;
    logic [CW-1:0]   r_cur, n_cur;
    logic [CW-1:0]   r_txidx, n_txidx;
    logic            r_wit, n_wit;
    logic            r_any, n_any;
    logic            r_fail, n_fail;
    logic            r_done, n_done;
    logic [2:0]      r_err, n_err;

    always_comb begin
        t_phase      ph;
        t_phase      enter_ph;
        logic        do_enter;
        logic        size_ev;
        logic [63:0] v;
        logic [63:0] acc;
        logic [63:0] lo;
        logic [63:0] idxw;
        logic [CW-1:0] vc;
        logic [6:0]  flen;
        logic        ev_item, ev_stack, ev_out, ev_endout, ev_tx, ev_start, ev_fin;
        logic        ev_fail;
        logic [2:0]  fcode;
        logic        txd;
        logic [2:0]  code;

        n_phase = r_phase; n_fbc = r_fbc; n_acc = r_acc; n_pbl = r_pbl;
        n_total = r_total; n_list = r_list; n_bytes = r_bytes; n_stack = r_stack;
        n_txrem = r_txrem; n_cur = r_cur; n_txidx = r_txidx;
        n_wit = r_wit; n_any = r_any; n_fail = r_fail; n_done = r_done; n_err = r_err;
        enter_ph = r_phase; do_enter = 1'b0; size_ev = 1'b0; v = '0; acc = '0;
        lo = '0; idxw = '0; vc = '0; flen = 7'd4;
        ev_item = 1'b0; ev_stack = 1'b0; ev_out = 1'b0; ev_endout = 1'b0;
        ev_tx = 1'b0; ev_start = 1'b0; ev_fin = 1'b0; ev_fail = 1'b0;
        fcode = txp_pkg::ERR_NONE; txd = 1'b0; code = txp_pkg::ERR_NONE;
        ph = r_phase;
        o_res = '0;

        if (i_kind) begin
            // end of stream: report and rearm
            code = (!r_fail && !r_done) ? txp_pkg::ERR_TRUNC : r_err;
            o_res.field_code   = txp_pkg::FC_IDLE;
            o_res.message_done = r_done;
            o_res.error_flag   = (code != txp_pkg::ERR_NONE);
            o_res.error_code   = code;
            n_phase = PH_START; n_fbc = '0; n_acc = '0; n_pbl = '0;
            n_total = '0; n_list = '0; n_bytes = '0; n_stack = '0;
            n_txrem = '0; n_cur = '0; n_txidx = '0;
            n_wit = 1'b0; n_any = 1'b0; n_fail = 1'b0; n_done = 1'b0;
            n_err = txp_pkg::ERR_NONE;
        end else begin
            if (r_phase == PH_START)
                ph = (i_cfg.parse_mode == txp_pkg::MODE_TX) ? PH_VERSION : PH_HEADER;
            n_phase = ph;

            if (ph == PH_VERSION || ph == PH_INCOUNT || ph == PH_MARKER ||
                ph == PH_OUTCOUNT || ph == PH_LOCK) begin
                idxw = 64'(r_txidx);
            end else if (ph != PH_HEADER && ph != PH_TXCOUNT && ph != PH_IDLE) begin
                idxw = 64'(r_cur);
            end

            unique case (ph)
                PH_INCOUNT, PH_SSLEN, PH_OUTCOUNT, PH_SPKLEN,
                PH_WSTACK, PH_WLEN, PH_TXCOUNT: begin
                    if (r_pbl == 4'd0) begin
                        if (i_byte < 8'd253) begin
                            v = 64'(i_byte);
                            size_ev = 1'b1;
                        end else begin
                            n_pbl = (i_byte == 8'd253) ? 4'd2 :
                                    (i_byte == 8'd254) ? 4'd4 : 4'd8;
                            n_acc = '0;
                            n_fbc = '0;
                        end
                    end else begin
                        acc = r_acc | (64'(i_byte) << {r_fbc[2:0], 3'b000});
                        n_acc = acc;
                        n_fbc = r_fbc + 7'd1;
                        n_pbl = r_pbl - 4'd1;
                        if (n_pbl == 4'd0) begin
                            lo = (n_fbc == 7'd2) ? 64'd253 :
                                 (n_fbc == 7'd4) ? 64'h1_0000 : 64'h1_0000_0000;
                            if (acc < lo) begin
                                ev_fail = 1'b1; fcode = txp_pkg::ERR_NONCANON;
                            end else begin
                                v = acc;
                                size_ev = 1'b1;
                            end
                        end
                    end
                end
                PH_MARKER: begin
                    if (i_byte == 8'd1) begin
                        n_wit = 1'b1; do_enter = 1'b1; enter_ph = PH_INCOUNT;
                    end else if (i_byte == 8'd0) begin
                        do_enter = 1'b1; enter_ph = PH_LOCK;
                    end else begin
                        ev_fail = 1'b1; fcode = txp_pkg::ERR_MARKER;
                    end
                end
                PH_SSBYTE, PH_SPKBYTE, PH_WBYTE: begin
                    n_bytes = r_bytes - CW'(1);
                    if (n_bytes == '0) begin
                        if (ph == PH_SSBYTE) begin
                            do_enter = 1'b1; enter_ph = PH_SEQ;
                        end else if (ph == PH_SPKBYTE) begin
                            ev_out = 1'b1;
                        end else begin
                            ev_item = 1'b1;
                        end
                    end
                end
                PH_IDLE: ;
                default: begin
                    n_fbc = r_fbc + 7'd1;
                    flen = (ph == PH_HASH) ? 7'd32 : (ph == PH_VALUE) ? 7'd8 :
                           (ph == PH_HEADER) ? 7'd80 : 7'd4;
                    if (n_fbc >= flen) begin
                        do_enter = 1'b1;
                        case (ph)
                            PH_VERSION: enter_ph = PH_INCOUNT;
                            PH_HASH:    enter_ph = PH_INDEX;
                            PH_INDEX:   enter_ph = PH_SSLEN;
                            PH_SEQ: begin
                                n_list = r_list - CW'(1);
                                n_cur  = r_cur + CW'(1);
                                enter_ph = (n_list != '0) ? PH_HASH : PH_OUTCOUNT;
                            end
                            PH_VALUE:   enter_ph = PH_SPKLEN;
                            PH_LOCK: begin
                                do_enter = 1'b0; ev_tx = 1'b1;
                            end
                            default: begin
                                if (i_cfg.parse_mode >= 2'd2) enter_ph = PH_TXCOUNT;
                                else begin
                                    do_enter = 1'b0; ev_fin = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            endcase

            if (size_ev) begin
                vc = v[CW-1:0];
                if (v > 64'(i_cfg.size_limit) || (v >> CW) != 64'd0) begin
                    ev_fail = 1'b1; fcode = txp_pkg::ERR_OVERSIZE;
                end else begin
                    case (ph)
                        PH_INCOUNT: begin
                            if (v == 64'd0 && i_cfg.witness_allowed && !r_wit) begin
                                do_enter = 1'b1; enter_ph = PH_MARKER;
                            end else begin
                                n_total = vc; n_list = vc; n_cur = '0;
                                do_enter = 1'b1;
                                enter_ph = (v != 64'd0) ? PH_HASH : PH_OUTCOUNT;
                            end
                        end
                        PH_SSLEN: begin
                            do_enter = 1'b1;
                            if (v != 64'd0) begin
                                n_bytes = vc; enter_ph = PH_SSBYTE;
                            end else enter_ph = PH_SEQ;
                        end
                        PH_OUTCOUNT: begin
                            n_list = vc; n_cur = '0;
                            if (v != 64'd0) begin
                                do_enter = 1'b1; enter_ph = PH_VALUE;
                            end else ev_endout = 1'b1;
                        end
                        PH_SPKLEN: begin
                            if (v != 64'd0) begin
                                n_bytes = vc; do_enter = 1'b1; enter_ph = PH_SPKBYTE;
                            end else ev_out = 1'b1;
                        end
                        PH_WSTACK: begin
                            n_stack = vc;
                            if (v != 64'd0) begin
                                n_any = 1'b1; do_enter = 1'b1; enter_ph = PH_WLEN;
                            end else ev_stack = 1'b1;
                        end
                        PH_WLEN: begin
                            if (v != 64'd0) begin
                                n_bytes = vc; do_enter = 1'b1; enter_ph = PH_WBYTE;
                            end else ev_item = 1'b1;
                        end
                        default: begin
                            n_txrem = vc; n_txidx = '0;
                            if (v != 64'd0) ev_start = 1'b1;
                            else ev_fin = 1'b1;
                        end
                    endcase
                end
            end

            // follow-on list bookkeeping
            if (ev_item) begin
                n_stack = n_stack - CW'(1);
                if (n_stack != '0) begin
                    do_enter = 1'b1; enter_ph = PH_WLEN;
                end else ev_stack = 1'b1;
            end
            if (ev_stack) begin
                n_list = n_list - CW'(1);
                n_cur  = n_cur + CW'(1);
                if (n_list != '0) begin
                    do_enter = 1'b1; enter_ph = PH_WSTACK;
                end else if (!n_any) begin
                    ev_fail = 1'b1; fcode = txp_pkg::ERR_EMPTY_WIT;
                end else begin
                    do_enter = 1'b1; enter_ph = PH_LOCK;
                end
            end
            if (ev_out) begin
                n_list = n_list - CW'(1);
                n_cur  = n_cur + CW'(1);
                if (n_list != '0) begin
                    do_enter = 1'b1; enter_ph = PH_VALUE;
                end else ev_endout = 1'b1;
            end
            if (ev_endout) begin
                if (n_wit) begin
                    n_list = n_total; n_cur = '0;
                    if (n_total != '0) begin
                        do_enter = 1'b1; enter_ph = PH_WSTACK;
                    end else begin
                        ev_fail = 1'b1; fcode = txp_pkg::ERR_EMPTY_WIT;
                    end
                end else begin
                    do_enter = 1'b1; enter_ph = PH_LOCK;
                end
            end
            if (ev_tx) begin
                txd = 1'b1;
                if (i_cfg.parse_mode >= 2'd2) begin
                    n_txrem = r_txrem - CW'(1);
                    n_txidx = r_txidx + CW'(1);
                    if (n_txrem == '0) ev_fin = 1'b1;
                    else ev_start = 1'b1;
                end else ev_fin = 1'b1;
            end
            if (ev_start) begin
                n_wit = 1'b0; n_any = 1'b0;
                do_enter = 1'b1; enter_ph = PH_VERSION;
            end

            if (do_enter) begin
                n_phase = enter_ph; n_fbc = '0; n_pbl = '0;
            end
            if (ev_fail) begin
                n_err = fcode; n_fail = 1'b1; n_phase = PH_IDLE;
            end
            if (ev_fin) begin
                n_done = 1'b1; n_phase = PH_IDLE;
            end

            o_res.field_code   = 5'(ph);
            o_res.byte_echo    = i_byte;
            o_res.item_index   = idxw[24:0];
            o_res.tx_done      = txd;
            o_res.message_done = n_done;
            o_res.error_flag   = n_fail;
            o_res.error_code   = n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START; r_fbc <= '0; r_acc <= '0; r_pbl <= '0;
            r_total <= '0; r_list <= '0; r_bytes <= '0; r_stack <= '0;
            r_txrem <= '0; r_cur <= '0; r_txidx <= '0;
            r_wit <= 1'b0; r_any <= 1'b0; r_fail <= 1'b0; r_done <= 1'b0;
            r_err <= txp_pkg::ERR_NONE;
        end else if (i_en) begin
            r_phase <= n_phase; r_fbc <= n_fbc; r_acc <= n_acc; r_pbl <= n_pbl;
            r_total <= n_total; r_list <= n_list; r_bytes <= n_bytes; r_stack <= n_stack;
            r_txrem <= n_txrem; r_cur <= n_cur; r_txidx <= n_txidx;
            r_wit <= n_wit; r_any <= n_any; r_fail <= n_fail; r_done <= n_done;
            r_err <= n_err;
        end
    end

endmodule
`default_nettype wire

// ----- dv/tx_block_stream_checker.sv -----
// Checker for tx_block_stream_parser: watches the byte, result and register channels,
// predicts each result in its own copy of the parser and compares field by field.
// Depends on txp_pkg for the result layout and the register and error codes.
`default_nettype none
module tx_block_stream_checker
    import txp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    input  wire logic        i_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,
    input  wire logic        i_s_axis_tuser,
    input  wire logic        i_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [47:0] i_m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [25:0] i_cfg_wdata,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [4:0] PH_VERSION  = 5'd0;
    localparam logic [4:0] PH_INCOUNT  = 5'd1;
    localparam logic [4:0] PH_MARKER   = 5'd2;
    localparam logic [4:0] PH_HASH     = 5'd3;
    localparam logic [4:0] PH_INDEX    = 5'd4;
    localparam logic [4:0] PH_SSLEN    = 5'd5;
    localparam logic [4:0] PH_SSBYTE   = 5'd6;
    localparam logic [4:0] PH_SEQ      = 5'd7;
    localparam logic [4:0] PH_OUTCOUNT = 5'd8;
    localparam logic [4:0] PH_VALUE    = 5'd9;
    localparam logic [4:0] PH_SPKLEN   = 5'd10;
    localparam logic [4:0] PH_SPKBYTE  = 5'd11;
    localparam logic [4:0] PH_WSTACK   = 5'd12;
    localparam logic [4:0] PH_WLEN     = 5'd13;
    localparam logic [4:0] PH_WBYTE    = 5'd14;
    localparam logic [4:0] PH_HEADER   = 5'd16;
    localparam logic [4:0] PH_TXCOUNT  = 5'd17;
    localparam logic [4:0] PH_START    = 5'd19;
    localparam logic [63:0] COUNT_MAX  = 64'h3FF_FFFF;

    // register copies
    logic [1:0]  mode;
    logic        wit_ok;
    logic [25:0] max_sz;

    // parser copy
    logic [4:0]  ph;
    int unsigned fbc;
    logic [63:0] acc;
    int unsigned pleft;
    logic [25:0] in_total, list_rem, bytes_rem, stack_rem, tx_rem, cur_idx, tx_idx;
    bit          st_wit, st_any, st_fail, st_done, txd;
    logic [2:0]  err;

    t_result expected_results[$];

    function automatic void clear_parser();
        ph = PH_START; fbc = 0; acc = '0; pleft = 0;
        in_total = '0; list_rem = '0; bytes_rem = '0; stack_rem = '0;
        tx_rem = '0; cur_idx = '0; tx_idx = '0;
        st_wit = 0; st_any = 0; st_fail = 0; st_done = 0; err = ERR_NONE;
    endfunction

    function automatic void fail_with(logic [2:0] code);
        err = code; st_fail = 1; ph = FC_IDLE;
    endfunction

    function automatic void finish_msg();
        st_done = 1; ph = FC_IDLE;
    endfunction

    function automatic void enter_ph(logic [4:0] p);
        ph = p; fbc = 0; pleft = 0;
    endfunction

    function automatic void start_tx();
        st_wit = 0; st_any = 0; enter_ph(PH_VERSION);
    endfunction

    function automatic void end_outputs();
        if (st_wit) begin
            list_rem = in_total; cur_idx = '0;
            if (in_total != 0) enter_ph(PH_WSTACK); else fail_with(ERR_EMPTY_WIT);
        end else begin
            enter_ph(FC_LOCK);
        end
    endfunction

    function automatic void next_output();
        list_rem--; cur_idx++;
        if (list_rem != 0) enter_ph(PH_VALUE); else end_outputs();
    endfunction

    function automatic void next_stack();
        list_rem--; cur_idx++;
        if (list_rem != 0) enter_ph(PH_WSTACK);
        else if (!st_any) fail_with(ERR_EMPTY_WIT);
        else enter_ph(FC_LOCK);
    endfunction

    function automatic void next_witness_item();
        stack_rem--;
        if (stack_rem != 0) enter_ph(PH_WLEN); else next_stack();
    endfunction

    function automatic void take_size(logic [25:0] v);
        case (ph)
            PH_INCOUNT: begin
                if (v == 0 && wit_ok && !st_wit) begin
                    enter_ph(PH_MARKER);
                end else begin
                    in_total = v; list_rem = v; cur_idx = '0;
                    if (v != 0) enter_ph(PH_HASH); else enter_ph(PH_OUTCOUNT);
                end
            end
            PH_SSLEN: begin
                if (v != 0) begin bytes_rem = v; enter_ph(PH_SSBYTE); end
                else enter_ph(PH_SEQ);
            end
            PH_OUTCOUNT: begin
                list_rem = v; cur_idx = '0;
                if (v != 0) enter_ph(PH_VALUE); else end_outputs();
            end
            PH_SPKLEN: begin
                if (v != 0) begin bytes_rem = v; enter_ph(PH_SPKBYTE); end
                else next_output();
            end
            PH_WSTACK: begin
                stack_rem = v;
                if (v != 0) begin st_any = 1; enter_ph(PH_WLEN); end
                else next_stack();
            end
            PH_WLEN: begin
                if (v != 0) begin bytes_rem = v; enter_ph(PH_WBYTE); end
                else next_witness_item();
            end
            default: begin
                tx_rem = v; tx_idx = '0;
                if (v != 0) start_tx(); else finish_msg();
            end
        endcase
    endfunction

    function automatic void check_size(logic [63:0] v);
        if (v > {38'd0, max_sz} || v > COUNT_MAX) fail_with(ERR_OVERSIZE);
        else take_size(v[25:0]);
    endfunction

    function automatic void size_byte(logic [7:0] b);
        logic [63:0] lo;
        if (pleft == 0) begin
            if (b < 8'd253) begin
                check_size({56'd0, b});
            end else begin
                pleft = (b == 8'd253) ? 2 : (b == 8'd254) ? 4 : 8;
                acc = '0; fbc = 0;
            end
        end else begin
            acc |= {56'd0, b} << (8 * (fbc & 7));
            fbc++; pleft--;
            if (pleft == 0) begin
                lo = (fbc == 2) ? 64'd253 : (fbc == 4) ? 64'h1_0000 : 64'h1_0000_0000;
                if (acc < lo) fail_with(ERR_NONCANON); else check_size(acc);
            end
        end
    endfunction

    function automatic void consume(logic [4:0] p, logic [7:0] b);
        int unsigned len;
        case (p)
            PH_INCOUNT, PH_SSLEN, PH_OUTCOUNT, PH_SPKLEN, PH_WSTACK, PH_WLEN, PH_TXCOUNT:
                size_byte(b);
            PH_MARKER: begin
                if (b == 8'd1) begin st_wit = 1; enter_ph(PH_INCOUNT); end
                else if (b == 8'd0) enter_ph(FC_LOCK);
                else fail_with(ERR_MARKER);
            end
            PH_SSBYTE, PH_SPKBYTE, PH_WBYTE: begin
                bytes_rem--;
                if (bytes_rem == 0) begin
                    if (p == PH_SSBYTE) enter_ph(PH_SEQ);
                    else if (p == PH_SPKBYTE) next_output();
                    else next_witness_item();
                end
            end
            default: begin
                len = (p == PH_HASH) ? 32 : (p == PH_VALUE) ? 8 : (p == PH_HEADER) ? 80 : 4;
                fbc++;
                if (fbc >= len) begin
                    case (p)
                        PH_VERSION: enter_ph(PH_INCOUNT);
                        PH_HASH:    enter_ph(PH_INDEX);
                        PH_INDEX:   enter_ph(PH_SSLEN);
                        PH_VALUE:   enter_ph(PH_SPKLEN);
                        PH_SEQ: begin
                            list_rem--; cur_idx++;
                            if (list_rem != 0) enter_ph(PH_HASH); else enter_ph(PH_OUTCOUNT);
                        end
                        FC_LOCK: begin
                            txd = 1;
                            if (mode >= 2) begin
                                tx_rem--; tx_idx++;
                                if (tx_rem == 0) finish_msg(); else start_tx();
                            end else begin
                                finish_msg();
                            end
                        end
                        default: begin
                            if (mode >= 2) enter_ph(PH_TXCOUNT); else finish_msg();
                        end
                    endcase
                end
            end
        endcase
    endfunction

    function automatic t_result predict_result(logic kind, logic [7:0] b);
        t_result r;
        logic [4:0] p;
        logic [25:0] idx;
        txd = 0;
        if (kind) begin
            r = '0;
            r.field_code   = FC_IDLE;
            r.message_done = st_done;
            r.error_code   = (!st_fail && !st_done) ? ERR_TRUNC : err;
            r.error_flag   = (r.error_code != ERR_NONE);
            clear_parser();
            return r;
        end
        if (ph == PH_START) enter_ph(mode == MODE_TX ? PH_VERSION : PH_HEADER);
        p = ph;
        idx = '0;
        if (p == PH_VERSION || p == PH_INCOUNT || p == PH_MARKER || p == PH_OUTCOUNT ||
            p == FC_LOCK)
            idx = tx_idx;
        else if (p != PH_HEADER && p != PH_TXCOUNT && p != FC_IDLE)
            idx = cur_idx;
        if (p != FC_IDLE) consume(p, b);
        r.field_code   = p;
        r.byte_echo    = b;
        r.item_index   = idx[24:0];
        r.tx_done      = txd;
        r.message_done = st_done;
        r.error_flag   = st_fail;
        r.error_code   = err;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            mode = MODE_TX; wit_ok = 1'b1; max_sz = 26'd33554432;
            clear_parser();
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                // tdata carries field_code in its lowest bits
                got = {i_m_axis_tdata[4:0], i_m_axis_tdata[12:5], i_m_axis_tdata[37:13],
                       i_m_axis_tdata[38], i_m_axis_tdata[39], i_m_axis_tdata[40],
                       i_m_axis_tdata[43:41]};
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: %h", got);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.field_code !== want.field_code) begin
                        $error("field_code exp %0d got %0d", want.field_code, got.field_code);
                        o_fail_count++;
                    end
                    if (got.byte_echo !== want.byte_echo) begin
                        $error("byte_echo exp %0d got %0d", want.byte_echo, got.byte_echo);
                        o_fail_count++;
                    end
                    if (got.item_index !== want.item_index) begin
                        $error("item_index exp %0d got %0d", want.item_index, got.item_index);
                        o_fail_count++;
                    end
                    if (got.tx_done !== want.tx_done) begin
                        $error("tx_done exp %0d got %0d", want.tx_done, got.tx_done);
                        o_fail_count++;
                    end
                    if (got.message_done !== want.message_done) begin
                        $error("message_done exp %0d got %0d",
                               want.message_done, got.message_done);
                        o_fail_count++;
                    end
                    if (got.error_flag !== want.error_flag) begin
                        $error("error_flag exp %0d got %0d", want.error_flag, got.error_flag);
                        o_fail_count++;
                    end
                    if (got.error_code !== want.error_code) begin
                        $error("error_code exp %0d got %0d", want.error_code, got.error_code);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_PARSE_MODE: mode   = i_cfg_wdata[1:0];
                    CFG_WITNESS:    wit_ok = i_cfg_wdata[0];
                    CFG_SIZE_LIMIT: max_sz = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_results.insert(expected_results.size(),
                                        predict_result(i_s_axis_tuser, i_s_axis_tdata));
        end
        o_pending = expected_results.size();
    end

endmodule
`default_nettype wire

// ----- dv/tx_block_stream_parser_test.sv -----
// Top of the parser testbench: clock, reset, byte stimulus and register writes.
// Depends on txp_pkg, tx_block_stream_parser and tx_block_stream_checker.
`default_nettype none
module tx_block_stream_parser_test;
    import txp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1050;

    logic        clk, rst_n;
    logic        s_tvalid, s_tready, s_tuser;
    logic [7:0]  s_tdata;
    logic        m_tvalid, m_tready;
    logic [47:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [25:0] cfg_wdata;
    int          fail_count, pending;

    int          tx_idle_pct, rx_idle_pct;
    int          requests_sent;
    bit          want_hold;
    int          hold_left;
    logic [1:0]  cur_mode;
    bit          cur_wit;
    logic [7:0]  msg[$];

    tx_block_stream_parser dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata)
    );

    tx_block_stream_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_axis_tvalid(s_tvalid), .i_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .i_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .i_m_axis_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (want_hold) begin
                want_hold = 0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_request(logic kind, logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
        requests_sent++;
        if (requests_sent < RANDOM_ITEMS / 3) begin
            tx_idle_pct = 26; rx_idle_pct = 68;
        end else if (requests_sent < 2 * RANDOM_ITEMS / 3) begin
            tx_idle_pct = 68; rx_idle_pct = 26;
        end else begin
            tx_idle_pct = 0; rx_idle_pct = 0;
        end
    endtask

    // drop valid and let every outstanding result drain
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] addr, logic [25:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (addr == CFG_PARSE_MODE) cur_mode = value[1:0];
        if (addr == CFG_WITNESS) cur_wit = value[0];
    endtask

    task automatic add_byte(logic [7:0] b);
        msg.insert(msg.size(), b);
    endtask

    task automatic send_msg_then_end();
        foreach (msg[i]) send_request(1'b0, msg[i]);
        send_request(1'b1, 8'($urandom_range(255)));
        msg.delete();
    endtask

    task automatic put_random(int n);
        repeat (n) add_byte(8'($urandom_range(255)));
    endtask

    task automatic put_size(int unsigned v);
        if (v >= 253) begin
            add_byte(8'd253);
            add_byte(v[7:0]);
            add_byte(v[15:8]);
        end else begin
            add_byte(v[7:0]);
        end
    endtask

    task automatic put_tx();
        int n_in, n_out, n_stk, k;
        bit ext;
        ext = cur_wit && ($urandom_range(2) == 0);
        put_random(4);
        if (ext) begin
            add_byte(8'd0);
            add_byte(8'd1);
        end
        n_in = (cur_wit || ext) ? $urandom_range(1, 2) : $urandom_range(0, 2);
        put_size(n_in);
        repeat (n_in) begin
            put_random(36);
            k = ($urandom_range(15) == 0) ? 260 : $urandom_range(0, 3);
            put_size(k);
            put_random(k + 4);
        end
        n_out = $urandom_range(0, 2);
        put_size(n_out);
        repeat (n_out) begin
            put_random(8);
            k = $urandom_range(0, 3);
            put_size(k);
            put_random(k);
        end
        if (ext) begin
            for (int s = 0; s < n_in; s++) begin
                n_stk = (s == 0) ? $urandom_range(1, 2) : $urandom_range(0, 2);
                put_size(n_stk);
                repeat (n_stk) begin
                    k = $urandom_range(0, 3);
                    put_size(k);
                    put_random(k);
                end
            end
        end
        put_random(4);
    endtask

    task automatic put_message();
        int n_tx;
        if (cur_mode == MODE_TX) begin
            put_tx();
        end else begin
            put_random(80);
            if (cur_mode != 2'd1) begin
                n_tx = $urandom_range(0, 2);
                put_size(n_tx);
                repeat (n_tx) put_tx();
            end
        end
        if ($urandom_range(5) == 0) put_random($urandom_range(1, 3));
    endtask

    initial begin
        int pick;
        bit held;
        rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
        cfg_we = 1'b0; cfg_addr = CFG_PARSE_MODE; cfg_wdata = '0;
        tx_idle_pct = 26; rx_idle_pct = 68;
        requests_sent = 0; want_hold = 0; held = 0;
        cur_mode = MODE_TX; cur_wit = 1'b1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // end of stream on an idle parser reports truncation
        send_request(1'b1, 8'd0);
        // noncanonical two-byte count, then trailing bytes
        msg = '{8'h01, 8'h00, 8'h00, 8'h00, 8'd253, 8'h10, 8'h00, 8'hFF, 8'h00};
        send_msg_then_end();
        // eight-byte count beyond the counter range
        msg = '{8'h02, 8'h00, 8'h00, 8'h00, 8'd255};
        repeat (8) add_byte(8'hFF);
        send_msg_then_end();
        // bad marker, then the empty transaction marker
        msg = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05};
        send_msg_then_end();
        msg = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44};
        send_msg_then_end();
        // extended form with no inputs and no outputs has an empty witness
        msg = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00};
        send_msg_then_end();
        // size limits at both ends
        write_reg(CFG_SIZE_LIMIT, 26'd0);
        msg = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h01};
        send_msg_then_end();
        write_reg(CFG_SIZE_LIMIT, 26'd33554432);
        msg = '{8'h01, 8'h00, 8'h00, 8'h00, 8'd254, 8'h00, 8'h00, 8'h00, 8'h02};
        send_msg_then_end();
        write_reg(CFG_WITNESS, 26'd0);
        write_reg(CFG_PARSE_MODE, 26'd1);

        while (requests_sent < RANDOM_ITEMS) begin
            if (!held && requests_sent > RANDOM_ITEMS / 2) begin
                held = 1;
                want_hold = 1;
            end
            if ($urandom_range(3) == 0) begin
                pick = $urandom_range(2);
                if (pick == 0) write_reg(CFG_PARSE_MODE, 26'($urandom_range(3)));
                else if (pick == 1) write_reg(CFG_WITNESS, 26'($urandom_range(1)));
                else write_reg(CFG_SIZE_LIMIT, ($urandom_range(3) == 0) ?
                               26'($urandom_range(0, 3)) : 26'd33554432);
            end
            put_message();
            pick = $urandom_range(9);
            // break some messages: cut short, corrupt a byte, or pure noise
            if (pick == 0) begin
                while (msg.size() > 1 && $urandom_range(3) != 0) void'(msg.pop_back());
            end else if (pick == 1) begin
                msg[$urandom_range(msg.size() - 1)] = 8'($urandom_range(255));
            end else if (pick == 2) begin
                msg.delete();
                put_random($urandom_range(1, 12));
            end
            send_msg_then_end();
        end

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
